[rtl/ttei_pkg.sv]
package ttei_pkg;

    localparam int MaxIter   = 32;
    localparam int FracBits  = 13;
    localparam int ZW        = 18;
    localparam int PW        = 2 * ZW;
    localparam int SW        = PW + 2;
    localparam int CntW      = 6;

    localparam logic signed [ZW-1:0] ZMax = 18'sd131071;
    localparam logic signed [ZW-1:0] ZMin = -18'sd131072;
    localparam logic signed [SW-1:0] EscLimit = SW'(64'sd4 <<< (2 * FracBits));

    typedef struct packed {
        logic signed [ZW-1:0] zr;
        logic signed [ZW-1:0] zi;
        logic signed [ZW-1:0] zj;
        logic signed [15:0]   cr;
        logic signed [15:0]   ci;
        logic signed [15:0]   cj;
        logic [CntW-1:0]      count;
        logic                 done;
    } t_iter;

    // products of one step, held between the two halves of an iteration
    typedef struct packed {
        logic signed [PW-1:0] rr;
        logic signed [PW-1:0] ii;
        logic signed [PW-1:0] jj;
        logic signed [PW-1:0] ri;
        logic signed [PW-1:0] rj;
        logic signed [PW-1:0] ij;
        logic signed [15:0]   cr;
        logic signed [15:0]   ci;
        logic signed [15:0]   cj;
        logic [CntW-1:0]      count;
        logic                 done;
    } t_prod;

    function automatic logic signed [ZW-1:0] finish(input logic signed [SW-1:0] wide,
                                                      input logic signed [15:0] c);
        logic signed [SW:0] rnd;
        logic signed [SW:0] v;
        begin
            rnd = ((SW+1)'(wide) + (SW+1)'(1 <<< (FracBits - 1))) >>> FracBits;
            v   = rnd + (SW+1)'(c);
            if (v > (SW+1)'(ZMax))
                finish = ZMax;
            else if (v < (SW+1)'(ZMin))
                finish = ZMin;
            else
                finish = v[ZW-1:0];
        end
    endfunction

endpackage

[rtl/ttei_mul.sv]
// first half of an iteration: six products
module ttei_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttei_pkg::t_iter     i_d,
    output logic                o_valid,
    output ttei_pkg::t_prod     o_d
);
    import ttei_pkg::*;

    t_prod r_d;
    logic  r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.rr    <= i_d.zr * i_d.zr;
            r_d.ii    <= i_d.zi * i_d.zi;
            r_d.jj    <= i_d.zj * i_d.zj;
            r_d.ri    <= i_d.zr * i_d.zi;
            r_d.rj    <= i_d.zr * i_d.zj;
            r_d.ij    <= i_d.zi * i_d.zj;
            r_d.cr    <= i_d.cr;
            r_d.ci    <= i_d.ci;
            r_d.cj    <= i_d.cj;
            r_d.count <= i_d.count;
            r_d.done  <= i_d.done;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

[rtl/ttei_upd.sv]
// second half: escape test, sums, rounding, clamp
module ttei_upd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ttei_pkg::t_prod     i_d,
    input  logic [ttei_pkg::CntW-1:0] i_step,
    output logic                o_valid,
    output ttei_pkg::t_iter     o_d
);
    import ttei_pkg::*;

    t_iter r_d;
    t_iter n_d;
    logic  r_valid;
    logic signed [SW-1:0] mag;

    always_comb begin
        mag = SW'(i_d.rr) + SW'(i_d.ii) + SW'(i_d.jj);
        n_d = '0;
        n_d.cr    = i_d.cr;
        n_d.ci    = i_d.ci;
        n_d.cj    = i_d.cj;
        n_d.zr    = finish(SW'(i_d.rr) - SW'(i_d.ii) + SW'(i_d.jj), i_d.cr);
        n_d.zi    = finish((SW'(i_d.ri) <<< 1) + SW'(i_d.ij), i_d.ci);
        n_d.zj    = finish((SW'(i_d.rj) <<< 1) + SW'(i_d.ij), i_d.cj);
        n_d.count = i_d.count;
        n_d.done  = i_d.done;
        if (!i_d.done && mag > EscLimit) begin
            n_d.done  = 1'b1;
            n_d.count = i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule

[rtl/three_term_escape_time_iteration_top.sv]
// channel | signals                       | dir
// in      | i_valid, o_stall, i_c_*       | to block
// out     | o_valid, i_stall, o_iter*, .. | from block
//
// Each iteration is a multiply stage and an update stage.
// One point enters per cycle while o_stall is low; the whole pipe advances together.
// Reset (synchronous, active low) clears only the stage valid bits.
// A stall at the output freezes every stage; o_stall is i_stall when the
// last stage holds a beat, so empty bubbles still drain.
module three_term_escape_time_iteration_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_c_real,
    input  logic signed [15:0] i_c_i,
    input  logic signed [15:0] i_c_j,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_iteration_count,
    output logic        o_escaped
);
    import ttei_pkg::*;

    logic  en;
    t_iter entry_d;
    logic  v_s [0:MaxIter];
    t_iter d_s [0:MaxIter];
    logic  v_m [0:MaxIter-1];
    t_prod d_m [0:MaxIter-1];

    assign en = !(v_s[MaxIter] && i_stall);
    assign o_stall = !en;

    always_comb begin
        entry_d       = '0;
        entry_d.cr    = i_c_real;
        entry_d.ci    = i_c_i;
        entry_d.cj    = i_c_j;
        entry_d.count = CntW'(MaxIter);
    end

    assign v_s[0] = i_valid;
    assign d_s[0] = entry_d;

    for (genvar k = 0; k < MaxIter; k++) begin : g_it
        ttei_mul u_mul (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v_s[k]), .i_d(d_s[k]),
            .o_valid(v_m[k]), .o_d(d_m[k])
        );
        ttei_upd u_upd (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(v_m[k]), .i_d(d_m[k]), .i_step(CntW'(k)),
            .o_valid(v_s[k+1]), .o_d(d_s[k+1])
        );
    end

    assign o_valid           = v_s[MaxIter];
    assign o_iteration_count = d_s[MaxIter].count;
    assign o_escaped         = d_s[MaxIter].done;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_iteration_count))
        else $error("held beat changed");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_escaped |-> o_iteration_count == CntW'(MaxIter))
        else $error("bad count on no escape");
    a_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_escaped |-> o_iteration_count != 6'd0)
        else $error("escape at step zero");
`endif
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
    import ttei_pkg::*;

    typedef struct packed {
        logic [CntW-1:0] count;
        logic            escaped;
    } t_escape;

    typedef struct {
        logic signed [15:0] cr;
        logic signed [15:0] ci;
        logic signed [15:0] cj;
        bit                 typed;
        t_escape            want;
    } t_point_row;

    localparam int NumRandom  = 530;
    localparam int CycleLimit = 400000;
    localparam int DrainWait  = 2 * MaxIter + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [15:0] i_c_real = '0;
    logic signed [15:0] i_c_i = '0;
    logic signed [15:0] i_c_j = '0;
    logic o_stall;
    logic o_valid;
    logic [5:0] o_iteration_count;
    logic o_escaped;

    t_escape escape_q[$];
    int      n_errors = 0;
    int      n_cycles = 0;
    bit      no_idle = 1'b0;

    three_term_escape_time_iteration_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // Q10.26 -> Q5.13, round half up, add c, clamp
    function automatic longint rescale_add(longint wide, longint c);
        longint v;
        v = ((wide + (64'sd1 <<< (FracBits - 1))) >>> FracBits) + c;
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v;
    endfunction

    function automatic t_escape escape_time(logic signed [15:0] cr, logic signed [15:0] ci,
                                            logic signed [15:0] cj);
        longint zr, zi, zj, rr, ii, jj, nr, ni, nj;
        t_escape res;
        zr = 0; zi = 0; zj = 0;
        res.count = CntW'(MaxIter);
        res.escaped = 1'b0;
        for (int n = 0; n < MaxIter; n++) begin
            rr = zr * zr; ii = zi * zi; jj = zj * zj;
            if (rr + ii + jj > (64'sd4 <<< (2 * FracBits))) begin
                res.count = CntW'(n);
                res.escaped = 1'b1;
                break;
            end
            nr = rescale_add(rr - ii + jj, longint'(cr));
            ni = rescale_add(2 * (zr * zi) + zi * zj, longint'(ci));
            nj = rescale_add(2 * (zr * zj) + zj * zi, longint'(cj));
            zr = nr; zi = ni; zj = nj;
        end
        return res;
    endfunction

    task automatic send_point(logic signed [15:0] cr, logic signed [15:0] ci,
                              logic signed [15:0] cj);
        while (!no_idle && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_c_real <= cr;
        i_c_i    <= ci;
        i_c_j    <= cj;
        do @(posedge i_clk); while (o_stall);
        escape_q.insert(escape_q.size(), escape_time(cr, ci, cj));
    endtask

    always @(posedge i_clk) begin
        i_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 31);
    end

    // result beat checker
    always @(posedge i_clk) begin
        t_escape want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (escape_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                want = escape_q.pop_front();
                if (o_iteration_count !== want.count) begin
                    $error("iteration_count: expected %0d, got %0d", want.count,
                           o_iteration_count);
                    n_errors++;
                end
                if (o_escaped !== want.escaped) begin
                    $error("escaped: expected %0d, got %0d", want.escaped, o_escaped);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_point_row rows[$];
        logic signed [15:0] cr, ci, cj;
        int pick;

        // origin stays bounded; the corners escape at the first test after one step
        rows.insert(rows.size(), '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{6'd32, 1'b0}});
        rows.insert(rows.size(), '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, '{6'd1, 1'b1}});
        rows.insert(rows.size(), '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, '{6'd1, 1'b1}});
        rows.insert(rows.size(), '{-16'sh8000, 16'sd0, 16'sd0, 1'b1, '{6'd1, 1'b1}});
        rows.insert(rows.size(), '{16'sh7fff, 16'sd0, 16'sd0, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd0, -16'sh8000, 16'sd0, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd0, 16'sd0, 16'sh7fff, 1'b0, '0});
        rows.insert(rows.size(), '{-16'sd8192, 16'sd0, 16'sd0, 1'b0, '0});    // -1, period 2
        rows.insert(rows.size(), '{-16'sd16384, 16'sd0, 16'sd0, 1'b0, '0});   // -2, boundary
        rows.insert(rows.size(), '{16'sd2048, 16'sd0, 16'sd0, 1'b0, '0});     // 0.25, cusp
        rows.insert(rows.size(), '{16'sd2130, 16'sd0, 16'sd0, 1'b0, '0});     // just past cusp
        rows.insert(rows.size(), '{16'sd0, 16'sd8192, 16'sd0, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd0, 16'sd0, 16'sd8192, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd0, 16'sd0, -16'sd8192, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd16384, 16'sd0, 16'sd0, 1'b0, '0});    // exactly 2 after step
        rows.insert(rows.size(), '{16'sd1, 16'sd1, 16'sd1, 1'b0, '0});
        rows.insert(rows.size(), '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0});
        rows.insert(rows.size(), '{-16'sd6000, 16'sd5000, -16'sd3000, 1'b0, '0});
        rows.insert(rows.size(), '{16'sd3000, -16'sd4000, 16'sd7000, 1'b0, '0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            send_point(rows[k].cr, rows[k].ci, rows[k].cj);
            if (rows[k].typed && escape_q[$] !== rows[k].want) begin
                $error("directed row %0d: expected %0d/%0d, model gives %0d/%0d", k,
                       rows[k].want.count, rows[k].want.escaped,
                       escape_q[$].count, escape_q[$].escaped);
                n_errors++;
            end
        end

        // hold off until the pipe is empty
        i_valid <= 1'b0;
        while (escape_q.size() != 0) @(posedge i_clk);

        for (int k = 0; k < NumRandom; k++) begin
            no_idle = (k >= 150 && k < 280);
            pick = int'($urandom_range(9));
            if (pick < 3) begin
                cr = 16'($urandom); ci = 16'($urandom); cj = 16'($urandom);
            end else if (pick < 8) begin
                // near the set, where long runs happen
                cr = 16'($urandom_range(20000) - 14000);
                ci = 16'($urandom_range(12000) - 6000);
                cj = 16'($urandom_range(12000) - 6000);
            end else begin
                cr = 16'($urandom_range(4000) - 2000);
                ci = 16'($urandom_range(2000) - 1000);
                cj = 16'($urandom_range(2000) - 1000);
            end
            send_point(cr, ci, cj);
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        while (escape_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (n_errors == 0 && escape_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
